### sv/eamt_pkg.sv
package eamt_pkg;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_V4TO6  = 2'd1;
    localparam logic [1:0] ACT_V6TO4  = 2'd2;

    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_BADLEN   = 3'd1;
    localparam logic [2:0] STS_OVL6     = 3'd2;
    localparam logic [2:0] STS_OVL4     = 3'd3;
    localparam logic [2:0] STS_FULL     = 3'd4;
    localparam logic [2:0] STS_NOTFOUND = 3'd5;

    // ipv6 length of a pair is the ipv4 length plus this
    localparam logic [7:0] LEN6_OFFSET = 8'd96;

    typedef struct packed {
        logic [1:0]   action;
        logic [127:0] addr6;
        logic [7:0]   len6;
        logic [31:0]  addr4;
        logic [5:0]   len4;
    } t_req;

    // token that walks the cell chain, collecting the answer
    typedef struct packed {
        logic         vld;
        logic         ovl6;
        logic         ovl4;
        logic         free;
        logic         hit;
        logic [127:0] addr6;
        logic [31:0]  addr4;
    } t_tok;

    function automatic logic [31:0] mask4(input logic [5:0] len);
        logic [31:0] m;
        if (len >= 6'd32) begin
            m = '1;
        end else begin
            m = ~(32'hFFFF_FFFF >> len);
        end
        return m;
    endfunction

    function automatic logic [127:0] mask6(input logic [7:0] len);
        logic [127:0] m;
        if (len >= 8'd128) begin
            m = '1;
        end else begin
            m = ~({128{1'b1}} >> len);
        end
        return m;
    endfunction

endpackage

### sv/eamt_req_if.sv
interface eamt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [63:0] addr6_hi;
    logic [63:0] addr6_lo;
    logic [7:0]  prefix6_len;
    logic [31:0] addr4;
    logic [5:0]  prefix4_len;

    modport source (
        output valid, action, addr6_hi, addr6_lo, prefix6_len, addr4, prefix4_len,
        input  ready
    );
    modport sink (
        input  valid, action, addr6_hi, addr6_lo, prefix6_len, addr4, prefix4_len,
        output ready
    );
endinterface

### sv/eamt_rsp_if.sv
interface eamt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [63:0] out_addr6_hi;
    logic [63:0] out_addr6_lo;
    logic [31:0] out_addr4;

    modport source (
        output valid, status, out_addr6_hi, out_addr6_lo, out_addr4,
        input  ready
    );
    modport sink (
        input  valid, status, out_addr6_hi, out_addr6_lo, out_addr4,
        output ready
    );
endinterface

### sv/eamt_cell.sv
module eamt_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  eamt_pkg::t_req i_req,
    input  logic          i_start,
    input  logic          i_commit,
    input  eamt_pkg::t_tok i_tok,
    output eamt_pkg::t_tok o_tok
);
    import eamt_pkg::*;

    logic         r_vld;
    logic         r_claim;
    logic [127:0] r_v6;
    logic [31:0]  r_v4;
    logic [5:0]   r_len;
    t_tok         r_tok;
    t_tok         n_tok;

    logic [7:0]   w_elen6;
    logic [7:0]   w_min6;
    logic [5:0]   w_min4;
    logic         w_ovl6;
    logic         w_ovl4;
    logic         w_hit4;
    logic         w_hit6;
    logic [31:0]  w_host4;
    logic [31:0]  w_host6;

    assign w_elen6 = {2'b00, r_len} + LEN6_OFFSET;
    assign w_min6  = (i_req.len6 < w_elen6) ? i_req.len6 : w_elen6;
    assign w_min4  = (i_req.len4 < r_len) ? i_req.len4 : r_len;
    assign w_ovl6  = ((i_req.addr6 ^ r_v6) & mask6(w_min6)) == '0;
    assign w_ovl4  = ((i_req.addr4 ^ r_v4) & mask4(w_min4)) == '0;
    assign w_hit4  = ((i_req.addr4 ^ r_v4) & mask4(r_len)) == '0;
    assign w_hit6  = ((i_req.addr6 ^ r_v6) & mask6(w_elen6)) == '0;
    assign w_host4 = i_req.addr4 & ~mask4(r_len);
    assign w_host6 = i_req.addr6[31:0] & ~mask4(r_len);

    always_comb begin
        n_tok = i_tok;
        if (i_tok.vld) begin
            case (i_req.action)
                ACT_INSERT: begin
                    if (r_vld) begin
                        n_tok.ovl6 = i_tok.ovl6 | w_ovl6;
                        n_tok.ovl4 = i_tok.ovl4 | w_ovl4;
                    end else begin
                        n_tok.free = 1'b1;
                    end
                end
                ACT_V4TO6: begin
                    if (!i_tok.hit && r_vld && w_hit4) begin
                        n_tok.hit   = 1'b1;
                        n_tok.addr6 = r_v6 | {96'd0, w_host4};
                    end
                end
                ACT_V6TO4: begin
                    if (!i_tok.hit && r_vld && w_hit6) begin
                        n_tok.hit   = 1'b1;
                        n_tok.addr4 = r_v4 | w_host6;
                    end
                end
                default: begin
                    n_tok = i_tok;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= 1'b0;
            r_claim <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_tok <= n_tok;
            if (i_start) begin
                r_claim <= 1'b0;
            end else if (i_tok.vld && i_req.action == ACT_INSERT && !r_vld && !i_tok.free) begin
                // first free cell the insert passes takes the slot
                r_claim <= 1'b1;
            end
            if (i_commit && r_claim) begin
                r_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_commit && r_claim) begin
            r_v6  <= i_req.addr6 & mask6(i_req.len6);
            r_v4  <= i_req.addr4 & mask4(i_req.len4);
            r_len <= i_req.len4;
        end
    end

    assign o_tok = r_tok;

endmodule

### sv/explicit_address_map_table_core.sv
// Explicit address mapping table: IPv6/IPv4 prefix pairs with insert and
// translation in both directions.
// i_req carries one request: action, IPv6 address or prefix, IPv6 length,
// IPv4 address or prefix, IPv4 length. o_rsp returns one response per
// request: status and the translated addresses (zero unless the status is ok
// on a lookup).
// Each table entry lives in one cell of a chain. A request token walks the
// chain one cell per clock, picking up overlap flags, the first free slot and
// the first hit. An accepted request sets a start register that injects the
// token; it passes every cell, waits in the tail register and then loads the
// response register. The next request is accepted only once the response is
// loaded. An accepted insert is written into its claimed cell as its
// response is loaded.
// Reset empties the table: every entry is invalid.
// When o_rsp stalls the response is held and a finished token waits in a tail
// register; no new request is taken until the waiting response is loaded.
module explicit_address_map_table_core #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    eamt_req_if.sink   i_req,
    eamt_rsp_if.source o_rsp
);
    import eamt_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic         r_state;
    t_req         r_req;
    logic         r_start;
    t_tok         r_tail;
    logic         r_tail_vld;
    logic         r_o_vld;
    logic [2:0]   r_o_status;
    logic [127:0] r_o_addr6;
    logic [31:0]  r_o_addr4;

    t_tok         w_tok [TABLE_ENTRIES + 1];
    t_tok         w_inj;
    logic         w_accept;
    logic         w_done;
    logic         w_commit;
    logic         w_start;
    logic         w_badlen;
    logic [2:0]   n_status;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_start     = w_accept;
    assign w_done      = (r_state == S_RUN) && r_tail_vld && (!r_o_vld || o_rsp.ready);

    always_comb begin
        w_inj       = '0;
        w_inj.vld   = r_start;
    end
    assign w_tok[0] = w_inj;

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
            eamt_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_req    (r_req),
                .i_start  (w_start),
                .i_commit (w_commit),
                .i_tok    (w_tok[g]),
                .o_tok    (w_tok[g + 1])
            );
        end
    endgenerate

    // lengths must leave the same number of host bits
    assign w_badlen = (r_req.len6 > 8'd128) || (r_req.len4 > 6'd32) ||
                      (r_req.len6 != ({2'b00, r_req.len4} + LEN6_OFFSET));

    always_comb begin
        n_status = STS_NOTFOUND;
        unique case (r_req.action) inside
            ACT_INSERT: begin
                if (w_badlen) begin
                    n_status = STS_BADLEN;
                end else if (r_tail.ovl6) begin
                    n_status = STS_OVL6;
                end else if (r_tail.ovl4) begin
                    n_status = STS_OVL4;
                end else if (!r_tail.free) begin
                    n_status = STS_FULL;
                end else begin
                    n_status = STS_OK;
                end
            end
            ACT_V4TO6, ACT_V6TO4: begin
                n_status = r_tail.hit ? STS_OK : STS_NOTFOUND;
            end
            default: begin
                n_status = STS_NOTFOUND;
            end
        endcase
    end

    assign w_commit = w_done && (r_req.action == ACT_INSERT) && (n_status == STS_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_start    <= 1'b0;
            r_tail_vld <= 1'b0;
            r_o_vld    <= 1'b0;
        end else begin
            r_start <= w_accept;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (w_done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_tok[TABLE_ENTRIES].vld) begin
                r_tail_vld <= 1'b1;
            end else if (w_done) begin
                r_tail_vld <= 1'b0;
            end
            if (w_done) begin
                r_o_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req.action <= i_req.action;
            r_req.addr6  <= {i_req.addr6_hi, i_req.addr6_lo};
            r_req.len6   <= i_req.prefix6_len;
            r_req.addr4  <= i_req.addr4;
            r_req.len4   <= i_req.prefix4_len;
        end
        if (w_tok[TABLE_ENTRIES].vld) begin
            r_tail <= w_tok[TABLE_ENTRIES];
        end
        if (w_done) begin
            r_o_status <= n_status;
            r_o_addr6  <= (r_req.action == ACT_V4TO6 && n_status == STS_OK) ?
                          r_tail.addr6 : '0;
            r_o_addr4  <= (r_req.action == ACT_V6TO4 && n_status == STS_OK) ?
                          r_tail.addr4 : '0;
        end
    end

    assign o_rsp.valid        = r_o_vld;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.out_addr6_hi = r_o_addr6[127:64];
    assign o_rsp.out_addr6_lo = r_o_addr6[63:0];
    assign o_rsp.out_addr4    = r_o_addr4;

`ifndef SYNTHESIS
    a_commit_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |-> (r_req.action == ACT_INSERT) && !w_badlen && r_tail.free)
        else $error("table write without a clean insert");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> !r_tail_vld && !r_start)
        else $error("request accepted while a token is in flight");

    a_tail_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[TABLE_ENTRIES].vld |-> (r_state == S_RUN) && !r_tail_vld)
        else $error("token reached the tail outside a request");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> r_o_vld && (r_state == S_IDLE))
        else $error("finished request did not produce a response");
`endif

endmodule
